// File: rtl/core/glos_pkg.sv
// Shared constants, codes and unit handshake types for the grid line-of-sight block.
package glos_pkg;

    localparam int COORD_W  = 18;
    localparam int TILE_W   = 8;
    localparam int VAL_W    = 4;
    localparam int CFG_W    = 10;
    localparam int STEPS_W  = 11;
    localparam int DIST_W   = 19;
    localparam int SQ_W     = 38;
    localparam int REM_W    = 22;
    localparam int NUM_ITER = 19;

    localparam logic [STEPS_W-1:0] STEPS_MAX   = 11'd2047;
    localparam logic [DIST_W-1:0]  STEPS_SATQ  = 19'd2046;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;
    localparam logic [1:0] CMD_LOS   = 2'd3;

    localparam logic REG_MARGIN  = 1'b0;
    localparam logic REG_SPACING = 1'b1;

    localparam logic [CFG_W-1:0] MARGIN_RST  = 10'd205;
    localparam logic [CFG_W-1:0] SPACING_RST = 10'd51;

    localparam logic UNIT_SQRT = 1'b0;
    localparam logic UNIT_DIV  = 1'b1;

    typedef struct packed {
        logic               start;
        logic               mode;
        logic [SQ_W-1:0]    num;
        logic [STEPS_W-1:0] divisor;
    } unit_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] quo;
        logic [REM_W-1:0]  rem;
    } unit_rsp_t;

endpackage

// File: rtl/core/glos_in_if.sv
// Command channel interface: valid/ready plus one command item.
interface glos_in_if
    import glos_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic signed [TILE_W-1:0]  tile_x;
    logic signed [TILE_W-1:0]  tile_y;
    logic [VAL_W-1:0]          tile_value;
    logic signed [COORD_W-1:0] point_ax;
    logic signed [COORD_W-1:0] point_ay;
    logic signed [COORD_W-1:0] point_bx;
    logic signed [COORD_W-1:0] point_by;

    modport source (output valid, command, tile_x, tile_y, tile_value,
                    point_ax, point_ay, point_bx, point_by, input ready);
    modport sink   (input valid, command, tile_x, tile_y, tile_value,
                    point_ax, point_ay, point_bx, point_by, output ready);
endinterface

// File: rtl/core/glos_out_if.sv
// Result channel interface: valid/ready plus one result item.
interface glos_out_if
    import glos_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             pass_flag;
    logic [VAL_W-1:0] tile_out;

    modport source (output valid, pass_flag, tile_out, input ready);
    modport sink   (input valid, pass_flag, tile_out, output ready);
endinterface

// File: rtl/core/glos_tile_mem.sv
// Tile store: one write port, one registered read port.
module glos_tile_mem
    import glos_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);
    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/glos_divsqrt.sv
// Shared iterative unit: restoring square root or unsigned division, one bit per cycle.
module glos_divsqrt
    import glos_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);
    localparam int CNT_W = $clog2(NUM_ITER);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               mode_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SQ_W-1:0]    num_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIST_W-1:0]  root_reg;
    logic [STEPS_W-1:0] div_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb
    begin
        if (mode_reg == UNIT_SQRT)
        begin
            rem_sh = {rem_reg[REM_W-3:0], num_reg[SQ_W-1 -: 2]};
            trial  = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-2:0], num_reg[SQ_W-1]};
            trial  = {{(REM_W-STEPS_W){1'b0}}, div_reg};
        end
        ge = (rem_sh >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (cnt_reg == CNT_W'(NUM_ITER - 1)))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg <= req.mode;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            div_reg  <= req.divisor;
            if (req.mode == UNIT_DIV)
            begin
                num_reg <= {req.num[DIST_W-1:0], {(SQ_W-DIST_W){1'b0}}};
            end
            else
            begin
                num_reg <= req.num;
            end
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + CNT_W'(1);
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[DIST_W-2:0], ge};
            if (mode_reg == UNIT_DIV)
            begin
                num_reg <= {num_reg[SQ_W-2:0], 1'b0};
            end
            else
            begin
                num_reg <= {num_reg[SQ_W-3:0], 2'b00};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = root_reg;
    assign rsp.rem  = rem_reg;
endmodule

// File: rtl/core/grid_line_of_sight_top.sv
// Top level of the grid line-of-sight block: sequencer, registers and channel ports.
//
// Keeps a GRID_WIDTH x GRID_HEIGHT store of 4-bit tiles and answers one command per
// transfer on in_ch with one result transfer on out_ch. One command is worked on at a
// time; in_ch.ready is high only while the sequencer is idle, and a finished result
// sits in an output register so the next command can be taken while it waits.
// Steps: a write goes straight to the result; a read looks up one tile; a move check
// looks up the four corner tiles in turn, stopping at the first blocked one. Line of
// sight squares dx and dy on the multiplier, then makes four passes, 19 iterations
// each, through the shared square-root/divide unit (distance, step count, x and y
// increments), then looks up at most 2046 samples one after another. Samples
// advance by exact quotient/remainder increments, one add and compare per axis, and
// each one costs one read of the tile store. Tile contents are undefined until written;
// there is no clearing pass. Registers: collision_margin at byte 0, sample_spacing at
// byte 4 (a spacing of zero acts as one). Only paddr[2] is decoded.
module grid_line_of_sight_top
    import glos_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32,
    parameter int FRAC_BITS   = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    glos_in_if.sink           in_ch,
    glos_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = COORD_W + 1;   // point plus margin or offset headroom

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_UGO   = 4'd3;
    localparam logic [3:0] S_UWAIT = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_SAMP  = 4'd6;
    localparam logic [3:0] S_PADDR = 4'd7;
    localparam logic [3:0] S_PDATA = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // shared unit jobs
    localparam logic [1:0] OP_SQRT  = 2'd0;
    localparam logic [1:0] OP_STEPS = 2'd1;
    localparam logic [1:0] OP_DIVX  = 2'd2;
    localparam logic [1:0] OP_DIVY  = 2'd3;

    logic [3:0]                state_reg, state_next;
    logic [1:0]                cmd_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg;
    logic [COORD_W-1:0]        adx_reg, ady_reg;
    logic                      sdx_reg, sdy_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic                      mul_phase_reg;
    logic [1:0]                op_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic [STEPS_W-1:0]        sample_total_reg;
    logic [STEPS_W-1:0]        sample_index_reg;
    logic [COORD_W-1:0]        qx_reg, qy_reg, qx_acc_reg, qy_acc_reg;
    logic [STEPS_W-1:0]        rx_reg, ry_reg, rx_acc_reg, ry_acc_reg;
    logic [1:0]                corner_reg;
    logic signed [PW-1:0]      px_reg, py_reg;
    logic                      rd_oob_reg;
    logic                      fin_pass_reg;
    logic [VAL_W-1:0]          fin_tile_reg;
    logic                      res_valid_reg;
    logic                      res_pass_reg;
    logic [VAL_W-1:0]          res_tile_reg;
    logic [CFG_W-1:0]          margin_reg, spacing_reg;

    logic      in_xfer, out_xfer, cfg_wr;
    unit_req_t unit_req;
    unit_rsp_t unit_rsp;

    // ---------------- configuration port ----------------
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{(32-CFG_W){1'b0}}, (paddr[2] == REG_SPACING) ? spacing_reg : margin_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg  <= MARGIN_RST;
            spacing_reg <= SPACING_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SPACING)
            begin
                spacing_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                margin_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // ---------------- handshakes ----------------
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;

    // ---------------- input tile coordinates ----------------
    logic          in_tile_inb;
    logic [AW-1:0] in_tile_addr;

    assign in_tile_inb  = !in_ch.tile_x[TILE_W-1] && !in_ch.tile_y[TILE_W-1]
                          && ({1'b0, in_ch.tile_x} < (TILE_W+1)'(GRID_WIDTH))
                          && ({1'b0, in_ch.tile_y} < (TILE_W+1)'(GRID_HEIGHT));
    assign in_tile_addr = AW'(int'(in_ch.tile_y) * GRID_WIDTH + int'(in_ch.tile_x));

    // ---------------- point tile lookup ----------------
    logic signed [PW-1:0] ptx, pty;
    logic                 pt_inb;
    logic [AW-1:0]        pt_addr;

    assign ptx     = px_reg >>> FRAC_BITS;   // floor to tile
    assign pty     = py_reg >>> FRAC_BITS;
    assign pt_inb  = !ptx[PW-1] && !pty[PW-1]
                     && ($unsigned(ptx) < PW'(GRID_WIDTH))
                     && ($unsigned(pty) < PW'(GRID_HEIGHT));
    assign pt_addr = AW'(int'(pty) * GRID_WIDTH + int'(ptx));

    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    logic             mem_we;

    assign mem_raddr = (state_reg == S_IDLE) ? in_tile_addr : pt_addr;
    assign mem_we    = in_xfer && (in_ch.command == CMD_WRITE) && in_tile_inb;

    glos_tile_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (in_tile_addr),
        .wdata (in_ch.tile_value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- shared root / divide unit ----------------
    always_comb
    begin
        unit_req.start   = (state_reg == S_UGO);
        unit_req.mode    = UNIT_DIV;
        unit_req.num     = '0;
        unit_req.divisor = sample_total_reg;
        case (op_reg)
            OP_SQRT:
            begin
                unit_req.mode = UNIT_SQRT;
                unit_req.num  = sq_reg;
            end
            OP_STEPS:
            begin
                unit_req.num     = {{(SQ_W-DIST_W){1'b0}}, dist_reg};
                unit_req.divisor = (spacing_reg == '0) ? STEPS_W'(1)
                                                       : {1'b0, spacing_reg};
            end
            OP_DIVX:
            begin
                unit_req.num = {{(SQ_W-COORD_W){1'b0}}, adx_reg};
            end
            default:
            begin
                unit_req.num = {{(SQ_W-COORD_W){1'b0}}, ady_reg};
            end
        endcase
    end

    glos_divsqrt u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .rsp   (unit_rsp)
    );

    // ---------------- datapath helpers ----------------
    logic signed [PW-1:0]    dx_full, dy_full;
    logic [COORD_W-1:0]      mul_a;
    logic [2*COORD_W-1:0]    prod;
    logic [STEPS_W:0]        rx_sum, ry_sum;
    logic signed [PW-1:0]    ax_ext, ay_ext, m_ext, offx, offy;

    assign dx_full = PW'(in_ch.point_bx) - PW'(in_ch.point_ax);
    assign dy_full = PW'(in_ch.point_by) - PW'(in_ch.point_ay);
    assign mul_a   = mul_phase_reg ? ady_reg : adx_reg;
    assign prod    = mul_a * mul_a;
    assign rx_sum  = {1'b0, rx_acc_reg} + {1'b0, rx_reg};
    assign ry_sum  = {1'b0, ry_acc_reg} + {1'b0, ry_reg};
    assign ax_ext  = PW'(ax_reg);
    assign ay_ext  = PW'(ay_reg);
    assign m_ext   = $signed({{(PW-CFG_W){1'b0}}, margin_reg});

    always_comb
    begin
        if (cmd_reg == CMD_LOS)
        begin
            offx = sdx_reg ? -$signed({1'b0, qx_acc_reg}) : $signed({1'b0, qx_acc_reg});
            offy = sdy_reg ? -$signed({1'b0, qy_acc_reg}) : $signed({1'b0, qy_acc_reg});
        end
        else
        begin
            // corner order: (-,-) (-,+) (+,-) (+,+)
            offx = corner_reg[1] ? m_ext : -m_ext;
            offy = corner_reg[0] ? m_ext : -m_ext;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_ch.command)
                        CMD_WRITE: state_next = S_FIN;
                        CMD_READ:  state_next = S_READ;
                        CMD_MOVE:  state_next = S_SAMP;
                        default:   state_next = S_MUL;
                    endcase
                end
            end
            S_READ:  state_next = S_FIN;
            S_MUL:   state_next = mul_phase_reg ? S_UGO : S_MUL;
            S_UGO:   state_next = S_UWAIT;
            S_UWAIT:
            begin
                if (unit_rsp.done)
                begin
                    if (op_reg == OP_DIVY)
                    begin
                        state_next = (sample_total_reg == STEPS_W'(1)) ? S_FIN : S_STEP;
                    end
                    else
                    begin
                        state_next = S_UGO;
                    end
                end
            end
            S_STEP:  state_next = S_SAMP;
            S_SAMP:  state_next = S_PADDR;
            S_PADDR: state_next = pt_inb ? S_PDATA : S_FIN;
            S_PDATA:
            begin
                if (mem_rdata != '0)
                begin
                    state_next = S_FIN;
                end
                else if (cmd_reg == CMD_LOS)
                begin
                    state_next = (sample_index_reg == sample_total_reg - STEPS_W'(1))
                                 ? S_FIN : S_STEP;
                end
                else
                begin
                    state_next = (corner_reg == 2'd3) ? S_FIN : S_SAMP;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            res_valid_reg    <= 1'b0;
            sample_index_reg <= '0;
            sample_total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FIN) && (!res_valid_reg || out_ch.ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                res_valid_reg <= 1'b0;
            end
            if ((state_reg == S_UWAIT) && unit_rsp.done && (op_reg == OP_STEPS))
            begin
                sample_total_reg <= (unit_rsp.quo >= STEPS_SATQ)
                                    ? STEPS_MAX : STEPS_W'(unit_rsp.quo + DIST_W'(1));
            end
            if ((state_reg == S_UWAIT) && unit_rsp.done && (op_reg == OP_DIVY))
            begin
                sample_index_reg <= '0;
            end
            else if (state_reg == S_STEP)
            begin
                sample_index_reg <= sample_index_reg + STEPS_W'(1);
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_reg       <= in_ch.command;
                    ax_reg        <= in_ch.point_ax;
                    ay_reg        <= in_ch.point_ay;
                    sdx_reg       <= dx_full[PW-1];
                    sdy_reg       <= dy_full[PW-1];
                    adx_reg       <= COORD_W'(dx_full[PW-1] ? -dx_full : dx_full);
                    ady_reg       <= COORD_W'(dy_full[PW-1] ? -dy_full : dy_full);
                    mul_phase_reg <= 1'b0;
                    op_reg        <= OP_SQRT;
                    corner_reg    <= 2'd0;
                    rd_oob_reg    <= !in_tile_inb;
                    fin_pass_reg  <= 1'b1;
                    fin_tile_reg  <= '0;
                end
            end
            S_READ:
            begin
                fin_tile_reg <= rd_oob_reg ? VAL_W'(1) : mem_rdata;
            end
            S_MUL:
            begin
                mul_phase_reg <= 1'b1;
                if (mul_phase_reg)
                begin
                    sq_reg <= sq_reg + SQ_W'(prod);
                end
                else
                begin
                    sq_reg <= SQ_W'(prod);
                end
            end
            S_UWAIT:
            begin
                if (unit_rsp.done)
                begin
                    case (op_reg)
                        OP_SQRT:
                        begin
                            dist_reg <= unit_rsp.quo;
                            op_reg   <= OP_STEPS;
                        end
                        OP_STEPS:
                        begin
                            op_reg <= OP_DIVX;
                        end
                        OP_DIVX:
                        begin
                            qx_reg <= unit_rsp.quo[COORD_W-1:0];
                            rx_reg <= unit_rsp.rem[STEPS_W-1:0];
                            op_reg <= OP_DIVY;
                        end
                        default:
                        begin
                            qy_reg     <= unit_rsp.quo[COORD_W-1:0];
                            ry_reg     <= unit_rsp.rem[STEPS_W-1:0];
                            qx_acc_reg <= '0;
                            qy_acc_reg <= '0;
                            rx_acc_reg <= '0;
                            ry_acc_reg <= '0;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                // |d|*i/steps carried as quotient and remainder
                if (rx_sum >= {1'b0, sample_total_reg})
                begin
                    rx_acc_reg <= STEPS_W'(rx_sum - {1'b0, sample_total_reg});
                    qx_acc_reg <= qx_acc_reg + qx_reg + COORD_W'(1);
                end
                else
                begin
                    rx_acc_reg <= STEPS_W'(rx_sum);
                    qx_acc_reg <= qx_acc_reg + qx_reg;
                end
                if (ry_sum >= {1'b0, sample_total_reg})
                begin
                    ry_acc_reg <= STEPS_W'(ry_sum - {1'b0, sample_total_reg});
                    qy_acc_reg <= qy_acc_reg + qy_reg + COORD_W'(1);
                end
                else
                begin
                    ry_acc_reg <= STEPS_W'(ry_sum);
                    qy_acc_reg <= qy_acc_reg + qy_reg;
                end
            end
            S_SAMP:
            begin
                px_reg <= ax_ext + offx;
                py_reg <= ay_ext + offy;
            end
            S_PADDR:
            begin
                if (!pt_inb)
                begin
                    fin_pass_reg <= 1'b0;
                end
            end
            S_PDATA:
            begin
                if (mem_rdata != '0)
                begin
                    fin_pass_reg <= 1'b0;
                end
                corner_reg <= corner_reg + 2'd1;
            end
            default:
            begin
            end
        endcase

        if ((state_reg == S_FIN) && (!res_valid_reg || out_ch.ready))
        begin
            res_pass_reg <= fin_pass_reg;
            res_tile_reg <= fin_tile_reg;
        end
    end

    assign out_ch.valid     = res_valid_reg;
    assign out_ch.pass_flag = res_pass_reg;
    assign out_ch.tile_out  = res_tile_reg;

    // ---------------- checks ----------------
    a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        unit_req.start |-> !unit_rsp.busy)
        else $error("shared unit restarted while busy");

    a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (sample_index_reg < sample_total_reg - STEPS_W'(1)))
        else $error("sample index past last interior sample");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("command accepted but sequencer stayed idle");

    a_data_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PDATA) |-> ($past(state_reg) == S_PADDR))
        else $error("tile data checked without a lookup");
endmodule
